[design/frt_pkg.sv]
// Package with the shared formats, constants and exponential tables of the ray transport block.
`default_nettype none
package frt_pkg;

  localparam int unsigned EXP_TABLE_SIZE = 256;
  localparam int unsigned IdxW = $clog2(EXP_TABLE_SIZE);
  localparam int unsigned IntSteps = 18;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW = $clog2(FifoDepth);
  localparam logic [39:0] TauMax = 40'd255 << 32;
  localparam logic [39:0] TauSmall = 40'd429496;
  localparam logic [24:0] One24 = 25'd16777216;

  typedef logic [30:0] frac_tab_t [EXP_TABLE_SIZE + 1];
  typedef logic [30:0] int_tab_t [IntSteps];

  typedef struct packed {
    logic [24:0] a;
    logic [31:0] b;
    logic        last;
  } zone_t;

  // Restoring shift-and-subtract quotient, used only while the tables are elaborated.
  function automatic logic [63:0] div_by(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] exp_inv(input logic [63:0] d);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 62;
    pos  = term;
    neg  = '0;
    for (int n = 1; n <= 24; n++) begin
      term = div_by(term, d * 64'(n));
      if ((n % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    return ((pos - neg) + (64'd1 << 31)) >> 32;
  endfunction

  function automatic logic [63:0] mul30(input logic [63:0] x, input logic [63:0] y);
    return (x * y + (64'd1 << 29)) >> 30;
  endfunction

  function automatic frac_tab_t build_frac();
    frac_tab_t   t;
    logic [63:0] ef;
    logic [63:0] cur;
    ef   = exp_inv(64'(EXP_TABLE_SIZE));
    cur  = 64'd1 << 30;
    t[0] = cur[30:0];
    for (int k = 1; k <= EXP_TABLE_SIZE; k++) begin
      cur  = mul30(cur, ef);
      t[k] = cur[30:0];
    end
    return t;
  endfunction

  function automatic int_tab_t build_int();
    int_tab_t    t;
    logic [63:0] e1;
    logic [63:0] cur;
    e1   = exp_inv(64'd1);
    cur  = 64'd1 << 30;
    t[0] = cur[30:0];
    for (int k = 1; k < IntSteps; k++) begin
      cur  = mul30(cur, e1);
      t[k] = cur[30:0];
    end
    return t;
  endfunction

  localparam frac_tab_t FracTab = build_frac();
  localparam int_tab_t IntTab = build_int();

endpackage
`default_nettype wire

[design/frt_front.sv]
// Front pipeline: optical depth, zone transmission and zone emission for each word.
`default_nettype none
module frt_front import frt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [23:0] opacity_i,
  input  wire logic [23:0] path_length_i,
  input  wire logic [31:0] source_value_i,
  input  wire logic        last_zone_i,
  output logic             push_o,
  input  wire logic        push_ready_i,
  output zone_t            zone_o
);

  logic        s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  logic        en;
  logic [47:0] tau_full;
  logic [39:0] tau_sat;
  logic [39:0] s1_tau_q;
  logic [31:0] s1_src_q;
  logic        s1_last_q;

  logic [IdxW-1:0] idx;
  logic [IdxW:0]   idx_next;
  logic [31:0]     rem;
  logic [30:0]     s2_t0_q, s2_diff_q;
  logic [31:0]     s2_rem_q, s2_src_q;
  logic [7:0]      s2_ip_q;
  logic            s2_small_q, s2_last_q;
  logic [18:0]     s2_tau_q;

  logic [62:0] interp;
  logic        deep;
  logic [30:0] s3_fv_q, s3_int_q;
  logic        s3_deep_q, s3_small_q, s3_last_q;
  logic [18:0] s3_tau_q;
  logic [31:0] s3_src_q;

  logic [61:0] prod4;
  logic [61:0] v;
  logic [61:0] a_full;
  logic [24:0] s4_a_q;
  logic        s4_small_q, s4_last_q;
  logic [18:0] s4_tau_q;
  logic [31:0] s4_src_q;

  logic [24:0] mop;
  logic [56:0] prod5;
  logic [56:0] b_full;
  zone_t       s5_q;

  assign en         = !s5_valid_q || push_ready_i;
  assign in_ready_o = en;
  assign push_o     = s5_valid_q;
  assign zone_o     = s5_q;

  assign tau_full = 48'(opacity_i) * 48'(path_length_i);
  assign tau_sat  = (tau_full > 48'(TauMax)) ? TauMax : tau_full[39:0];

  assign idx      = s1_tau_q[31 -: IdxW];
  assign idx_next = {1'b0, idx} + (IdxW+1)'(1);
  assign rem      = {s1_tau_q[31-IdxW:0], {IdxW{1'b0}}};

  assign interp = 63'(s2_diff_q) * 63'(s2_rem_q);
  assign deep   = s2_ip_q >= 8'(IntSteps);

  assign prod4  = 62'(s3_int_q) * 62'(s3_fv_q);
  assign v      = (prod4 + (62'd1 << 29)) >> 30;
  assign a_full = (v + 62'd32) >> 6;

  assign mop    = s4_small_q ? 25'(s4_tau_q) : (One24 - s4_a_q);
  assign prod5  = 57'(mop) * 57'(s4_src_q);
  assign b_full = s4_small_q ? ((prod5 + (57'd1 << 31)) >> 32)
                             : ((prod5 + (57'd1 << 23)) >> 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_tau_q   <= tau_sat;
      s1_src_q   <= source_value_i;
      s1_last_q  <= last_zone_i;

      s2_t0_q    <= FracTab[idx];
      s2_diff_q  <= FracTab[idx] - FracTab[idx_next];
      s2_rem_q   <= rem;
      s2_ip_q    <= s1_tau_q[39:32];
      s2_small_q <= s1_tau_q <= TauSmall;
      s2_tau_q   <= s1_tau_q[18:0];
      s2_src_q   <= s1_src_q;
      s2_last_q  <= s1_last_q;

      s3_fv_q    <= s2_t0_q - interp[62:32];
      s3_int_q   <= deep ? '0 : IntTab[s2_ip_q[4:0]];
      s3_deep_q  <= deep;
      s3_small_q <= s2_small_q;
      s3_tau_q   <= s2_tau_q;
      s3_src_q   <= s2_src_q;
      s3_last_q  <= s2_last_q;

      s4_a_q     <= s3_deep_q ? '0 : a_full[24:0];
      s4_small_q <= s3_small_q;
      s4_tau_q   <= s3_tau_q;
      s4_src_q   <= s3_src_q;
      s4_last_q  <= s3_last_q;

      s5_q.a     <= s4_a_q;
      s5_q.b     <= b_full[31:0];
      s5_q.last  <= s4_last_q;
    end
  end

endmodule
`default_nettype wire

[design/frt_fifo.sv]
// Short queue of zone results between the front pipeline and the accumulator.
`default_nettype none
module frt_fifo import frt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  output logic       push_ready_o,
  input  zone_t      push_data_i,
  output logic       pop_valid_o,
  input  wire logic  pop_i,
  output zone_t      pop_data_o
);

  zone_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                do_push, do_pop;

  assign push_ready_o = cnt_q < (FifoPtrW+1)'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + FifoPtrW'(1);
      if (do_pop) rd_q <= rd_q + FifoPtrW'(1);
      if (do_push && !do_pop) cnt_q <= cnt_q + (FifoPtrW+1)'(1);
      else if (!do_push && do_pop) cnt_q <= cnt_q - (FifoPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

[design/frt_back.sv]
// Back end: running attenuation and emission per ray, with the result register.
`default_nettype none
module frt_back import frt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        zone_valid_i,
  output logic             zone_pop_o,
  input  zone_t            zone_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [24:0]      absorb_o,
  output logic [31:0]      selfem_o
);

  logic [24:0] atten_q;
  logic [31:0] emis_q;
  logic        out_valid_q;
  logic [24:0] absorb_q;
  logic [31:0] selfem_q;
  logic [49:0] atten_prod;
  logic [56:0] emis_prod;
  logic [49:0] atten_rnd;
  logic [56:0] emis_rnd;
  logic [33:0] emis_sum;
  logic [24:0] atten_d;
  logic [31:0] emis_d;

  assign zone_pop_o  = zone_valid_i && (!zone_i.last || !out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign absorb_o    = absorb_q;
  assign selfem_o    = selfem_q;

  assign atten_prod = 50'(atten_q) * 50'(zone_i.a);
  assign emis_prod  = 57'(emis_q) * 57'(zone_i.a);
  assign atten_rnd  = (atten_prod + (50'd1 << 23)) >> 24;
  assign emis_rnd   = (emis_prod + (57'd1 << 23)) >> 24;
  assign emis_sum   = 34'(emis_rnd[32:0]) + 34'(zone_i.b);
  assign atten_d    = atten_rnd[24:0];
  assign emis_d     = (emis_sum > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : emis_sum[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atten_q     <= One24;
      emis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (zone_pop_o) begin
        if (zone_i.last) begin
          atten_q     <= One24;
          emis_q      <= '0;
          out_valid_q <= 1'b1;
        end else begin
          atten_q <= atten_d;
          emis_q  <= emis_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (zone_pop_o && zone_i.last) begin
      absorb_q <= atten_d;
      selfem_q <= emis_d;
    end
  end

endmodule
`default_nettype wire

[design/flat_source_ray_transport.sv]
// Top level of the flat-source ray transport integrator.
// A last zone word passes the five front stages and the queue; its result is registered.
// Throughput: one zone word per cycle unless the queue or output stalls; the front is a
// five-stage pipeline; the accumulator pops one zone per cycle, with two multiplies.
// Reset: asynchronous, active low; clears the pipeline, the queue and the output, and sets
// the running attenuation to 1.0 and the running emission to 0. Tables are constants.
`default_nettype none
module flat_source_ray_transport import frt_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opacity [23:0], path_length [47:24], source_value [79:48]
  input  wire logic [79:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // absorb [24:0], selfem [56:25], zero [63:57]
  output logic [63:0]      m_axis_tdata
);

  logic        push, push_ready, pop_valid, pop;
  zone_t       push_data, pop_data;
  logic [24:0] absorb;
  logic [31:0] selfem;

  frt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opacity_i      (s_axis_tdata[23:0]),
    .path_length_i  (s_axis_tdata[47:24]),
    .source_value_i (s_axis_tdata[79:48]),
    .last_zone_i    (s_axis_tlast),
    .push_o         (push),
    .push_ready_i   (push_ready),
    .zone_o         (push_data)
  );

  frt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  frt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .zone_valid_i (pop_valid),
    .zone_pop_o   (pop),
    .zone_i       (pop_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .absorb_o     (absorb),
    .selfem_o     (selfem)
  );

  assign m_axis_tdata = {7'd0, selfem, absorb};

endmodule
`default_nettype wire

[design/frt_checker.sv]
// Port-level checker for the ray transport block and its bind to the top level.
`default_nettype none
module frt_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_absorb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[24:0] <= 25'd16777216)
    else $error("attenuation above one");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:57] == 7'd0)
    else $error("padding bits not zero");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind flat_source_ray_transport frt_port_checker u_frt_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
